FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion, checked at every edge including reset
`define ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: rtl/dwr_pkg.sv
`default_nettype none
package dwr_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned FILL_W  = 5;
    localparam int unsigned OUT_TDATA_W = 40;

    // operation carried in the input tuser
    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_POP_FRONT  = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_REMOVE     = 2'd3
    } t_op;

    // result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // per-cell control from the top level
    typedef struct packed {
        logic in_range;
        logic load;
        logic pop_front;
        logic remove;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: rtl/dwr_cell.sv
`default_nettype none
module dwr_cell (
    input  wire logic                         i_clk,
    input  wire dwr_pkg::t_cell_ctl           i_ctl,
    input  wire logic [dwr_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [dwr_pkg::VALUE_W-1:0]  i_right_data,
    input  wire logic                         i_found,
    output logic                              o_found,
    output logic [dwr_pkg::VALUE_W-1:0]       o_data
);
    import dwr_pkg::*;

    logic [VALUE_W-1:0] r_data;
    logic               hit;
    logic               shift;

    // match chain: set from the first matching cell onward
    assign hit     = i_ctl.in_range && (r_data == i_value);
    assign o_found = i_found || hit;
    assign shift   = i_ctl.pop_front || (i_ctl.remove && o_found);
    assign o_data  = r_data;

    // load at the back, or take the right neighbor to close a gap
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_value;
        end else if (shift) begin
            r_data <= i_right_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/deque_with_remove_by_value.sv
// output: the result of each input transfer is registered on the output register
// throughput: one item per cycle while the receiver takes results; remove does
// its search and compaction in one pass along the row of cells
// reset: synchronous active low, clears the fill count and the output valid;
// cell contents are left as they are and only read below the fill count
`default_nettype none
module deque_with_remove_by_value #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [dwr_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata, // [31:0] result_value, [36:32] fill_count
    output logic [1:0]       o_m_axis_tuser    // [1:0] status
);
    import dwr_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    t_status            r_out_status;
    logic [FILL_W-1:0]  r_out_fill;

    logic               accept;
    t_op                op;
    logic               empty;
    logic               full;
    logic [CW-1:0]      last_pos;
    t_cell_ctl          cell_ctl [DEPTH];
    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic               found [DEPTH+1];
    logic [VALUE_W-1:0] n_value;
    t_status            n_status;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign op              = t_op'(i_s_axis_tuser);
    assign empty           = (r_count == '0);
    assign full            = (r_count == CW'(DEPTH));
    assign last_pos        = r_count - CW'(1);

    // row of cells, front at index zero
    assign found[0] = 1'b0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] right_data;
        if (g == DEPTH - 1) begin : g_end
            assign right_data = cell_data[g];
        end else begin : g_mid
            assign right_data = cell_data[g+1];
        end

        always_comb begin
            cell_ctl[g].in_range  = (CW'(g) < r_count);
            cell_ctl[g].load      = accept && (op == OP_PUSH_BACK) && !full
                                    && (r_count == CW'(g));
            cell_ctl[g].pop_front = accept && (op == OP_POP_FRONT) && !empty;
            cell_ctl[g].remove    = accept && (op == OP_REMOVE);
        end

        dwr_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl[g]),
            .i_value      (i_s_axis_tdata),
            .i_right_data (right_data),
            .i_found      (found[g]),
            .o_found      (found[g+1]),
            .o_data       (cell_data[g])
        );
    end

    // result and next fill count
    always_comb begin
        n_value  = '0;
        n_status = ST_OK;
        n_count  = r_count;
        unique case (op)
            OP_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_value = cell_data[0];
                    n_count = last_pos;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_value = cell_data[last_pos[IW-1:0]];
                    n_count = last_pos;
                end
            end
            OP_REMOVE: begin
                if (found[DEPTH]) begin
                    n_count = last_pos;
                end else begin
                    n_status = ST_NOMATCH;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    // fill count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_out_value  <= n_value;
            r_out_status <= n_status;
            r_out_fill   <= FILL_W'(n_count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_fill, r_out_value};
    assign o_m_axis_tuser  = r_out_status;

endmodule
`default_nettype wire

FILE: rtl/dwr_checker.sv
`default_nettype none
`include "assert_macros.svh"
module dwr_checker #(
    parameter int unsigned DEPTH = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);
    import dwr_pkg::*;

    logic [FILL_W-1:0] fill;
    assign fill = o_m_axis_tdata[36:32];

    // no result leaves right after reset
    `ASSERT_ALL(a_idle_after_reset, i_clk, !$past(i_rst_n) |-> !o_m_axis_tvalid)

    // a stalled result holds its payload
    `ASSERT_RST(a_hold_on_stall, i_clk, i_rst_n,
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))

    // every input transfer is followed by a result
    `ASSERT_RST(a_result_after_transfer, i_clk, i_rst_n,
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)

    // full status only when the store is at its depth
    `ASSERT_RST(a_full_count, i_clk, i_rst_n,
        (o_m_axis_tvalid && o_m_axis_tuser == ST_FULL) |->
        (fill == FILL_W'(DEPTH) && o_m_axis_tdata[31:0] == '0))

    // empty status reports an empty store and a zero value
    `ASSERT_RST(a_empty_zero, i_clk, i_rst_n,
        (o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY) |->
        (fill == '0 && o_m_axis_tdata[31:0] == '0))

endmodule

bind deque_with_remove_by_value dwr_checker #(.DEPTH(DEPTH)) u_dwr_checker (.*);
`default_nettype wire

FILE: sim/deque_with_remove_by_value_test.sv
`timescale 1ns / 100ps
`default_nettype none
module deque_with_remove_by_value_test;
    import dwr_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 700;
    localparam int WATCHDOG_LIMIT = 4000;

    // one operation waiting to be sent
    typedef struct {
        t_op         op;
        logic [31:0] value;
        bit          wait_drain;
    } t_deque_op;

    // one predicted result
    typedef struct {
        logic [31:0] value;
        t_status     status;
        logic [4:0]  fill;
    } t_deque_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;    // [31:0] value
    logic [1:0]  i_s_axis_tuser = '0;    // [1:0] mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;         // [31:0] result_value, [36:32] fill_count
    logic [1:0]  o_m_axis_tuser;         // [1:0] status

    t_deque_op     pending_ops[$];
    t_deque_result expected_results[$];

    // shadow copy of the store
    logic [31:0] shadow_entries[DEPTH];
    int          shadow_count = 0;

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  results_drained = 1'b1;
    int  burst_left = 0;
    int  gap_left = 0;
    int  rx_style = 0;
    int  rx_cycle = 0;
    int  rx_hold = 0;

    deque_with_remove_by_value #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // apply one operation to the shadow store and queue its result
    task automatic apply_deque_op(input t_op op, input logic [31:0] val);
        t_deque_result res;
        int            i;
        int            hit;
        res.value  = '0;
        res.status = ST_OK;
        hit        = -1;
        case (op)
            OP_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_count] = val;
                    shadow_count++;
                end
            end
            OP_POP_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = shadow_entries[0];
                    for (i = 1; i < shadow_count; i++)
                        shadow_entries[i - 1] = shadow_entries[i];
                    shadow_count--;
                end
            end
            OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                    res.value = shadow_entries[shadow_count];
                end
            end
            default: begin
                // first match from the front, gap closed behind it
                for (i = 0; i < shadow_count; i++)
                    if (hit < 0 && shadow_entries[i] == val) hit = i;
                if (hit < 0) begin
                    res.status = ST_NOMATCH;
                end else begin
                    for (i = hit + 1; i < shadow_count; i++)
                        shadow_entries[i - 1] = shadow_entries[i];
                    shadow_count--;
                end
            end
        endcase
        res.fill = shadow_count[4:0];
        expected_results.push_back(res);
    endtask

    task automatic queue_op(input t_op op, input logic [31:0] val, input bit wait_drain);
        t_deque_op item;
        item.op         = op;
        item.value      = val;
        item.wait_drain = wait_drain;
        pending_ops.push_back(item);
    endtask

    // mostly a small pool so removes hit and duplicates occur
    function automatic logic [31:0] random_value();
        logic [31:0] pool[8];
        pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h0000_0005, 32'h5555_5555, 32'hAAAA_AAAA};
        if ($urandom_range(0, 9) < 6)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // sender: bursts and gaps, optional hold-off until all results are back
    always @(posedge i_clk) begin : drive_proc
        t_deque_op nxt;
        bit        take;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
            take = 1'b0;
            if (burst_left == 0) begin
                gap_left   = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 40);
            end
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_ops.size() != 0) begin
                if (!pending_ops[0].wait_drain || (results_drained && !i_s_axis_tvalid))
                    take = 1'b1;
            end
            if (take) begin
                nxt = pending_ops.pop_front();
                burst_left--;
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= nxt.value;
                i_s_axis_tuser  <= nxt.op;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check results, predict on input transfers, drive receiver ready
    always @(posedge i_clk) begin : monitor_proc
        t_deque_result want;
        logic [31:0]   got_value;
        logic [4:0]    got_fill;
        logic [1:0]    got_status;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            results_drained <= 1'b1;
        end else begin
            // result transfer
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_value  = o_m_axis_tdata[31:0];
                got_fill   = o_m_axis_tdata[36:32];
                got_status = o_m_axis_tuser;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: value %h status %0d fill %0d",
                                 got_value, got_status, got_fill);
                end else begin
                    want = expected_results.pop_front();
                    if (got_value !== want.value || got_status !== want.status ||
                            got_fill !== want.fill) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                     want.value, want.status, want.fill,
                                     got_value, got_status, got_fill);
                    end
                end
            end
            // input transfer
            if (i_s_axis_tvalid && o_s_axis_tready)
                apply_deque_op(t_op'(i_s_axis_tuser), i_s_axis_tdata);
            results_drained <= (expected_results.size() == 0);

            // receiver stall pattern; the style is redrawn at random from four kinds
            rx_cycle++;
            if (rx_cycle % 128 == 0)
                rx_style = $urandom_range(0, 3);
            case (rx_style)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: i_m_axis_tready <= (rx_cycle % 3 != 0);
                default: begin
                    if (rx_hold != 0) begin
                        rx_hold--;
                        i_m_axis_tready <= 1'b0;
                    end else if ($urandom_range(0, 9) == 0) begin
                        rx_hold = $urandom_range(1, 16);
                        i_m_axis_tready <= 1'b0;
                    end else begin
                        i_m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int  n;
        int  j;
        int  len;
        int  kind;
        int  r;
        int  phase;
        t_op op;

        // directed: empty store cases
        queue_op(OP_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_op(OP_POP_BACK, 32'hFFFF_FFFF, 1'b0);
        queue_op(OP_REMOVE, 32'h0000_0000, 1'b0);
        // removing the only entry empties the store
        queue_op(OP_PUSH_BACK, 32'h0000_0007, 1'b0);
        queue_op(OP_REMOVE, 32'h0000_0007, 1'b0);
        // value extremes and a duplicate
        queue_op(OP_PUSH_BACK, 32'h8000_0000, 1'b0);
        queue_op(OP_PUSH_BACK, 32'h7FFF_FFFF, 1'b0);
        queue_op(OP_PUSH_BACK, 32'h0000_0000, 1'b0);
        queue_op(OP_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
        queue_op(OP_PUSH_BACK, 32'h7FFF_FFFF, 1'b0);
        // first match from the front goes, second stays
        queue_op(OP_REMOVE, 32'h7FFF_FFFF, 1'b0);
        queue_op(OP_REMOVE, 32'h1234_5678, 1'b0);
        queue_op(OP_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_op(OP_POP_BACK, 32'h0000_0000, 1'b0);
        queue_op(OP_POP_FRONT, 32'h0000_0000, 1'b0);
        queue_op(OP_POP_BACK, 32'h0000_0000, 1'b0);
        queue_op(OP_POP_BACK, 32'h0000_0000, 1'b0);

        // random phases: fill, empty, mixed, remove heavy
        n     = 0;
        phase = 0;
        while (n < RANDOM_ITEMS) begin
            kind = (phase == 0) ? 0 : $urandom_range(0, 3);
            len  = (phase == 0) ? 40 : $urandom_range(10, 40);
            for (j = 0; j < len; j++) begin
                r = $urandom_range(0, 99);
                case (kind)
                    0: op = (r < 75) ? OP_PUSH_BACK : (r < 85) ? OP_POP_FRONT :
                            (r < 92) ? OP_POP_BACK : OP_REMOVE;
                    1: op = (r < 15) ? OP_PUSH_BACK : (r < 50) ? OP_POP_FRONT :
                            (r < 85) ? OP_POP_BACK : OP_REMOVE;
                    2: op = t_op'(r % 4);
                    default: op = (r < 45) ? OP_PUSH_BACK : (r < 55) ? OP_POP_FRONT :
                                  (r < 60) ? OP_POP_BACK : OP_REMOVE;
                endcase
                queue_op(op, random_value(),
                         j == 0 && (phase == 0 || $urandom_range(0, 4) == 0));
                n++;
            end
            phase++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all items sent, all results back, then a short tail
        do @(negedge i_clk); while (pending_ops.size() != 0 || i_s_axis_tvalid);
        do @(negedge i_clk); while (expected_results.size() != 0);
        repeat (8) @(negedge i_clk);

        if (expected_results.size() != 0)
            $display("%0d results never arrived", expected_results.size());
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/dwr_pkg.sv
rtl/dwr_cell.sv
rtl/deque_with_remove_by_value.sv
rtl/dwr_checker.sv
sim/deque_with_remove_by_value_test.sv
